### rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers of the Intel HEX record decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int unsigned MAX_RECORD_BYTES_DEF = 32;

  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  // word index of the registers, taken from paddr[2]
  localparam logic REG_BUFFER_LENGTH = 1'b0;

  typedef enum logic [8:0] {
    PH_SEEK    = 9'b000000001,
    PH_COUNT   = 9'b000000010,
    PH_ADDR_HI = 9'b000000100,
    PH_ADDR_LO = 9'b000001000,
    PH_TYPE    = 9'b000010000,
    PH_DATA    = 9'b000100000,
    PH_CKSUM   = 9'b001000000,
    PH_DONE    = 9'b010000000,
    PH_HALT    = 9'b100000000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_EOF   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_PREMATURE = 3'd0,
    ERR_DIGIT     = 3'd1,
    ERR_TOO_LONG  = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_EXT_COUNT = 3'd4,
    ERR_EOF_DATA  = 3'd5,
    ERR_TYPE      = 3'd6,
    ERR_CHECKSUM  = 3'd7
  } err_e;

  typedef enum logic [1:0] {
    REC_DATA = 2'd0,
    REC_EOF  = 2'd1,
    REC_EXT  = 2'd2
  } rtype_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/intel_hex_record_decoder.sv
// ----------------------------------------------------------------------------
// intel_hex_record_decoder
// Parses Intel HEX text, one character per word, into byte writes.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle unless a waiting output stalls; its
// write, end-of-file or error word appears on the master side in the next
// cycle from an output register, and the slave side keeps accepting while
// that word waits as long as the master side takes it in the same cycle.
// The per-character work is a hex digit decode, an 8-bit checksum add and,
// at the type byte, one 33-bit add and compare against buffer_length, all
// done in the cycle the character is accepted. tuser of the slave side set
// on a word clears the parser (upper address and write pointer too) before
// that character is used. After end of file or an error nothing more is
// produced until such a restart. There is no memory and no clearing pass.
// ----------------------------------------------------------------------------
module intel_hex_record_decoder #(
  parameter int unsigned MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ihex_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] ch
  input  logic                             s_axis_tuser,   // [0] restart

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] write_address, [39:32] write_data, [42:40] error_code
  output logic [ihex_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,   // [1:0] kind

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ihex_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned BL_W = $clog2(MAX_RECORD_BYTES + 1);

  logic [31:0] buffer_length_q;

  ihex_pkg::phase_e  phase_q, phase_d;
  logic              nib_q, nib_d;
  logic [3:0]        hn_q, hn_d;
  logic [7:0]        sum_q, sum_d;
  logic [BL_W-1:0]   bl_q, bl_d;
  logic [7:0]        rc_q, rc_d;
  logic [15:0]       ra_q, ra_d;
  ihex_pkg::rtype_e  rt_q, rt_d;
  logic [15:0]       up_q, up_d;
  logic [31:0]       wp_q, wp_d;

  logic              res_valid;
  ihex_pkg::kind_e   res_kind;
  logic [31:0]       res_addr;
  logic [7:0]        res_data;
  ihex_pkg::err_e    res_code;

  logic              out_valid_q;
  ihex_pkg::kind_e   out_kind_q;
  logic [31:0]       out_addr_q;
  logic [7:0]        out_data_q;
  ihex_pkg::err_e    out_code_q;

  logic              in_acc;
  logic              cfg_wr;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready &
                  (paddr[2] == ihex_pkg::REG_BUFFER_LENGTH);
  assign prdata = (paddr[2] == ihex_pkg::REG_BUFFER_LENGTH) ? buffer_length_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_length_q <= 32'd0;
    end else if (cfg_wr) begin
      buffer_length_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------- parser
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ihex_pkg::phase_e     ph;
    logic                 np;
    logic [3:0]           hn;
    logic [7:0]           sum;
    logic [BL_W-1:0]      bl;
    logic [7:0]           rc;
    logic [15:0]          ra;
    ihex_pkg::rtype_e     rt;
    logic [15:0]          up;
    logic [31:0]          wp;
    logic [7:0]           ch;
    ihex_pkg::hex_digit_t dig;
    logic [7:0]           byte_v;
    logic [7:0]           sum_n;
    logic [31:0]          start;
    logic [32:0]          end_addr;

    // state as seen by this character, after an optional restart
    ph  = s_axis_tuser ? ihex_pkg::PH_SEEK  : phase_q;
    np  = s_axis_tuser ? 1'b0               : nib_q;
    hn  = s_axis_tuser ? 4'd0               : hn_q;
    sum = s_axis_tuser ? 8'd0               : sum_q;
    bl  = s_axis_tuser ? '0                 : bl_q;
    rc  = s_axis_tuser ? 8'd0               : rc_q;
    ra  = s_axis_tuser ? 16'd0              : ra_q;
    rt  = s_axis_tuser ? ihex_pkg::REC_DATA : rt_q;
    up  = s_axis_tuser ? 16'd0              : up_q;
    wp  = s_axis_tuser ? 32'd0              : wp_q;

    ch       = s_axis_tdata;
    dig      = ihex_pkg::hex_decode(ch);
    byte_v   = {hn, dig.val};
    sum_n    = sum + byte_v;
    start    = {up, ra};
    end_addr = {1'b0, start} + {25'd0, rc};

    phase_d = ph;
    nib_d   = np;
    hn_d    = hn;
    sum_d   = sum;
    bl_d    = bl;
    rc_d    = rc;
    ra_d    = ra;
    rt_d    = rt;
    up_d    = up;
    wp_d    = wp;

    res_valid = 1'b0;
    res_kind  = ihex_pkg::KIND_WRITE;
    res_addr  = 32'd0;
    res_data  = 8'd0;
    res_code  = ihex_pkg::ERR_PREMATURE;

    unique case (ph)
      ihex_pkg::PH_DONE, ihex_pkg::PH_HALT: begin
      end
      ihex_pkg::PH_SEEK: begin
        if (ch == ihex_pkg::CHAR_NUL) begin
          phase_d   = ihex_pkg::PH_HALT;
          res_valid = 1'b1;
          res_kind  = ihex_pkg::KIND_ERROR;
          res_code  = ihex_pkg::ERR_PREMATURE;
        end else if (ch == ihex_pkg::CHAR_COLON) begin
          sum_d   = 8'd0;
          nib_d   = 1'b0;
          phase_d = ihex_pkg::PH_COUNT;
        end
      end
      default: begin
        if (ch == ihex_pkg::CHAR_NUL) begin
          phase_d   = ihex_pkg::PH_HALT;
          res_valid = 1'b1;
          res_kind  = ihex_pkg::KIND_ERROR;
          res_code  = ihex_pkg::ERR_PREMATURE;
        end else if (!dig.ok) begin
          phase_d   = ihex_pkg::PH_HALT;
          res_valid = 1'b1;
          res_kind  = ihex_pkg::KIND_ERROR;
          res_code  = ihex_pkg::ERR_DIGIT;
        end else if (!np) begin
          hn_d  = dig.val;
          nib_d = 1'b1;
        end else begin
          nib_d = 1'b0;
          sum_d = sum_n;
          unique case (ph)
            ihex_pkg::PH_COUNT: begin
              rc_d    = byte_v;
              phase_d = ihex_pkg::PH_ADDR_HI;
            end
            ihex_pkg::PH_ADDR_HI: begin
              ra_d    = {byte_v, 8'd0};
              phase_d = ihex_pkg::PH_ADDR_LO;
            end
            ihex_pkg::PH_ADDR_LO: begin
              ra_d    = {ra[15:8], byte_v};
              phase_d = ihex_pkg::PH_TYPE;
            end
            ihex_pkg::PH_TYPE: begin
              bl_d = rc[BL_W-1:0];
              priority if (rc > 8'(MAX_RECORD_BYTES)) begin
                phase_d   = ihex_pkg::PH_HALT;
                res_valid = 1'b1;
                res_kind  = ihex_pkg::KIND_ERROR;
                res_code  = ihex_pkg::ERR_TOO_LONG;
              end else if (byte_v == {6'd0, ihex_pkg::REC_DATA}) begin
                if (end_addr > {1'b0, buffer_length_q}) begin
                  phase_d   = ihex_pkg::PH_HALT;
                  res_valid = 1'b1;
                  res_kind  = ihex_pkg::KIND_ERROR;
                  res_code  = ihex_pkg::ERR_OVERFLOW;
                end else begin
                  wp_d    = start;
                  rt_d    = ihex_pkg::REC_DATA;
                  phase_d = (rc == 8'd0) ? ihex_pkg::PH_CKSUM : ihex_pkg::PH_DATA;
                end
              end else if (byte_v == {6'd0, ihex_pkg::REC_EXT}) begin
                if (rc != 8'd2) begin
                  phase_d   = ihex_pkg::PH_HALT;
                  res_valid = 1'b1;
                  res_kind  = ihex_pkg::KIND_ERROR;
                  res_code  = ihex_pkg::ERR_EXT_COUNT;
                end else begin
                  rt_d    = ihex_pkg::REC_EXT;
                  phase_d = ihex_pkg::PH_DATA;
                end
              end else if (byte_v == {6'd0, ihex_pkg::REC_EOF}) begin
                if (rc != 8'd0) begin
                  phase_d   = ihex_pkg::PH_HALT;
                  res_valid = 1'b1;
                  res_kind  = ihex_pkg::KIND_ERROR;
                  res_code  = ihex_pkg::ERR_EOF_DATA;
                end else begin
                  rt_d    = ihex_pkg::REC_EOF;
                  phase_d = ihex_pkg::PH_CKSUM;
                end
              end else begin
                phase_d   = ihex_pkg::PH_HALT;
                res_valid = 1'b1;
                res_kind  = ihex_pkg::KIND_ERROR;
                res_code  = ihex_pkg::ERR_TYPE;
              end
            end
            ihex_pkg::PH_DATA: begin
              bl_d    = bl - BL_W'(1);
              phase_d = (bl == BL_W'(1)) ? ihex_pkg::PH_CKSUM : ihex_pkg::PH_DATA;
              if (rt == ihex_pkg::REC_EXT) begin
                up_d = {up[7:0], byte_v};
              end else begin
                res_valid = 1'b1;
                res_kind  = ihex_pkg::KIND_WRITE;
                res_addr  = wp;
                res_data  = byte_v;
                wp_d      = wp + 32'd1;
              end
            end
            ihex_pkg::PH_CKSUM: begin
              if (sum_n != 8'd0) begin
                phase_d   = ihex_pkg::PH_HALT;
                res_valid = 1'b1;
                res_kind  = ihex_pkg::KIND_ERROR;
                res_code  = ihex_pkg::ERR_CHECKSUM;
              end else if (rt == ihex_pkg::REC_EOF) begin
                phase_d   = ihex_pkg::PH_DONE;
                res_valid = 1'b1;
                res_kind  = ihex_pkg::KIND_EOF;
              end else begin
                phase_d = ihex_pkg::PH_SEEK;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ihex_pkg::PH_SEEK;
      nib_q   <= 1'b0;
      hn_q    <= 4'd0;
      sum_q   <= 8'd0;
      bl_q    <= '0;
      rc_q    <= 8'd0;
      ra_q    <= 16'd0;
      rt_q    <= ihex_pkg::REC_DATA;
      up_q    <= 16'd0;
      wp_q    <= 32'd0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      hn_q    <= hn_d;
      sum_q   <= sum_d;
      bl_q    <= bl_d;
      rc_q    <= rc_d;
      ra_q    <= ra_d;
      rt_q    <= rt_d;
      up_q    <= up_d;
      wp_q    <= wp_d;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_kind_q <= res_kind;
      out_addr_q <= res_addr;
      out_data_q <= res_data;
      out_code_q <= res_code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {5'd0, out_code_q, out_data_q, out_addr_q};

  // ---------------------------------------------------------------- checks
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid && res_kind == ihex_pkg::KIND_ERROR |=> phase_q == ihex_pkg::PH_HALT)
    else $error("error word did not halt the parser");

  a_eof_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid && res_kind == ihex_pkg::KIND_EOF |=> phase_q == ihex_pkg::PH_DONE)
    else $error("end of file word did not stop the parser");

  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser &&
    (phase_q == ihex_pkg::PH_DONE || phase_q == ihex_pkg::PH_HALT) |-> !res_valid)
    else $error("word produced after the parser stopped");

  a_write_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid && res_kind == ihex_pkg::KIND_WRITE |->
    !s_axis_tuser && phase_q == ihex_pkg::PH_DATA && rt_q == ihex_pkg::REC_DATA)
    else $error("write word outside a data record");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_addr_q) &&
    $stable(out_kind_q))
    else $error("pending output word overwritten");

endmodule
